// File: rtl/core/fcr_pkg.sv
// ----------------------------------------------------------------------------
// fcr_pkg
// Shared types and constants for the count-based replacement cache: the
// controller states, the command and status groups, and the outcome codes.
// ----------------------------------------------------------------------------
package fcr_pkg;

  localparam int REG_COUNT   = 8;
  localparam int REG_IDX_W   = 3;
  localparam int WORD_W      = 32;
  localparam int OUT_WAY_W   = 3;
  localparam int OUT_COUNT_W = 16;

  typedef enum logic [1:0] {
    OUT_ABSENT = 2'd0,
    OUT_HIT    = 2'd1,
    OUT_FILL   = 2'd2,
    OUT_EVICT  = 2'd3
  } outcome_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LOOKUP,
    ST_SCAN,
    ST_EVICT
  } state_t;

  typedef struct packed {
    logic load;
    logic do_absent;
    logic do_hit;
    logic do_fill;
    logic scan_init;
    logic scan_step;
    logic do_evict;
  } cmd_t;

  typedef struct packed {
    logic present;
    logic hit;
    logic full;
    logic scan_last;
  } status_t;

endpackage

// File: rtl/core/frequency_count_cache_replacement.sv
// ----------------------------------------------------------------------------
// frequency_count_cache_replacement
// Fully associative tag cache with most-frequently-used replacement.
//
//   channel   handshake            word
//   --------  -------------------  ---------------------------------------
//   access    start / busy         access_value
//   result    done (1-cycle)       outcome, way_index, evicted_value,
//                                  use_count
//   config    cfg_valid/cfg_ready  cfg_index, cfg_data
//
// For absent, hit and fill accesses, done is registered from the lookup state; busy drops
// in the cycle done is high, so a new word can start then. An eviction first
// runs the one-way-per-cycle victim scan, then writes the chosen way.
// Reset clears valid bits, counters, fill level and the memory words.
// Results cannot be stalled; cfg_ready is always high.
// ----------------------------------------------------------------------------
module frequency_count_cache_replacement #(
  parameter int CACHE_WAYS   = 8,
  parameter int MEMORY_WORDS = 8,
  parameter int COUNT_WIDTH  = 16
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  output logic                              busy,
  input  logic signed [fcr_pkg::WORD_W-1:0] access_value,
  output logic                              done,
  output logic [1:0]                        outcome,
  output logic [fcr_pkg::OUT_WAY_W-1:0]     way_index,
  output logic signed [fcr_pkg::WORD_W-1:0] evicted_value,
  output logic [fcr_pkg::OUT_COUNT_W-1:0]   use_count,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [fcr_pkg::REG_IDX_W-1:0]     cfg_index,
  input  logic signed [fcr_pkg::WORD_W-1:0] cfg_data
);
  import fcr_pkg::*;

  cmd_t    cmd;
  status_t status;

  assign cfg_ready = 1'b1;

  fcr_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .busy   (busy),
    .status (status),
    .cmd    (cmd)
  );

  fcr_datapath #(
    .CACHE_WAYS   (CACHE_WAYS),
    .MEMORY_WORDS (MEMORY_WORDS),
    .COUNT_WIDTH  (COUNT_WIDTH)
  ) u_datapath (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .status        (status),
    .access_value  (access_value),
    .cfg_we        (cfg_valid & cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .done          (done),
    .outcome       (outcome),
    .way_index     (way_index),
    .evicted_value (evicted_value),
    .use_count     (use_count)
  );

endmodule

// File: rtl/core/fcr_ctrl.sv
// ----------------------------------------------------------------------------
// fcr_ctrl
// Sequencer for one access: lookup, optional victim scan over the ways,
// and the eviction write.
// ----------------------------------------------------------------------------
module fcr_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  output logic             busy,
  input  fcr_pkg::status_t status,
  output fcr_pkg::cmd_t    cmd
);
  import fcr_pkg::*;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    busy       = 1'b1;
    case (state)
      ST_IDLE: begin
        busy = 1'b0;
        if (start) begin
          cmd.load   = 1'b1;
          state_next = ST_LOOKUP;
        end
      end
      ST_LOOKUP: begin
        if (!status.present) begin
          cmd.do_absent = 1'b1;
          state_next    = ST_IDLE;
        end else if (status.hit) begin
          cmd.do_hit = 1'b1;
          state_next = ST_IDLE;
        end else if (!status.full) begin
          cmd.do_fill = 1'b1;
          state_next  = ST_IDLE;
        end else begin
          cmd.scan_init = 1'b1;
          state_next    = ST_SCAN;
        end
      end
      ST_SCAN: begin
        cmd.scan_step = 1'b1;
        if (status.scan_last) begin
          state_next = ST_EVICT;
        end
      end
      ST_EVICT: begin
        cmd.do_evict = 1'b1;
        state_next   = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

// File: rtl/core/fcr_datapath.sv
// ----------------------------------------------------------------------------
// fcr_datapath
// Backing-memory words, way tags, valid bits and use counters, the parallel
// tag compare, the serial victim search and the result registers.
// ----------------------------------------------------------------------------
module fcr_datapath #(
  parameter int CACHE_WAYS   = 8,
  parameter int MEMORY_WORDS = 8,
  parameter int COUNT_WIDTH  = 16
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  fcr_pkg::cmd_t                          cmd,
  output fcr_pkg::status_t                       status,
  input  logic signed [fcr_pkg::WORD_W-1:0]      access_value,
  input  logic                                   cfg_we,
  input  logic [fcr_pkg::REG_IDX_W-1:0]          cfg_index,
  input  logic signed [fcr_pkg::WORD_W-1:0]      cfg_data,
  output logic                                   done,
  output logic [1:0]                             outcome,
  output logic [fcr_pkg::OUT_WAY_W-1:0]          way_index,
  output logic signed [fcr_pkg::WORD_W-1:0]      evicted_value,
  output logic [fcr_pkg::OUT_COUNT_W-1:0]        use_count
);
  import fcr_pkg::*;

  localparam int WAY_W  = $clog2(CACHE_WAYS);
  localparam int FILL_W = $clog2(CACHE_WAYS + 1);

  logic [WORD_W-1:0]      mem_word [REG_COUNT];
  logic [WORD_W-1:0]      req;
  logic [WORD_W-1:0]      tag      [CACHE_WAYS];
  logic [CACHE_WAYS-1:0]  valid;
  logic [COUNT_WIDTH-1:0] count    [CACHE_WAYS];
  logic [FILL_W-1:0]      fill_level;
  logic [COUNT_WIDTH-1:0] best;
  logic [WAY_W-1:0]       victim;
  logic [WAY_W-1:0]       scan_idx;

  logic [CACHE_WAYS-1:0]  match;
  logic                   present;
  logic [WAY_W-1:0]       hit_idx;
  logic [COUNT_WIDTH-1:0] hit_count;
  logic [WAY_W-1:0]       fill_idx;
  logic                   take_scan;
  logic [WAY_W-1:0]       out_way;
  logic [COUNT_WIDTH-1:0] out_count;
  logic [WAY_W+OUT_WAY_W-1:0]         way_ext;
  logic [COUNT_WIDTH+OUT_COUNT_W-1:0] count_ext;

  always_comb begin
    present = 1'b0;
    for (int k = 0; k < MEMORY_WORDS; k++) begin
      if (mem_word[k] == req) present = 1'b1;
    end
  end

  always_comb begin
    for (int w = 0; w < CACHE_WAYS; w++) begin
      match[w] = valid[w] && (tag[w] == req);
    end
  end

  always_comb begin
    hit_idx = '0;
    for (int w = CACHE_WAYS - 1; w >= 0; w--) begin
      if (match[w]) hit_idx = WAY_W'(w);
    end
  end

  assign hit_count = (count[hit_idx] == {COUNT_WIDTH{1'b1}}) ?
                     count[hit_idx] : count[hit_idx] + COUNT_WIDTH'(1);
  assign fill_idx  = fill_level[WAY_W-1:0];
  assign take_scan = count[scan_idx] >= best;

  assign status.present   = present;
  assign status.hit       = |match;
  assign status.full      = fill_level == FILL_W'(CACHE_WAYS);
  assign status.scan_last = scan_idx == WAY_W'(CACHE_WAYS - 1);

  always_comb begin
    out_way   = '0;
    out_count = '0;
    if (cmd.do_hit) begin
      out_way   = hit_idx;
      out_count = hit_count;
    end else if (cmd.do_fill) begin
      out_way   = fill_idx;
      out_count = COUNT_WIDTH'(1);
    end else if (cmd.do_evict) begin
      out_way   = victim;
      out_count = COUNT_WIDTH'(1);
    end
  end

  assign way_ext   = {{OUT_WAY_W{1'b0}}, out_way};
  assign count_ext = {{OUT_COUNT_W{1'b0}}, out_count};

  // control state and counters
  always_ff @(posedge clk) begin
    if (rst) begin
      valid      <= '0;
      fill_level <= '0;
      done       <= 1'b0;
      for (int w = 0; w < CACHE_WAYS; w++) count[w] <= '0;
      for (int k = 0; k < REG_COUNT; k++) mem_word[k] <= '0;
    end else begin
      done <= cmd.do_absent | cmd.do_hit | cmd.do_fill | cmd.do_evict;
      if (cfg_we) begin
        mem_word[cfg_index] <= cfg_data;
      end
      if (cmd.do_hit) begin
        count[hit_idx] <= hit_count;
      end
      if (cmd.do_fill) begin
        valid[fill_idx] <= 1'b1;
        count[fill_idx] <= COUNT_WIDTH'(1);
        fill_level      <= fill_level + FILL_W'(1);
      end
      if (cmd.do_evict) begin
        valid[victim] <= 1'b1;
        count[victim] <= COUNT_WIDTH'(1);
      end
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req <= access_value;
    end
    if (cmd.do_fill) begin
      tag[fill_idx] <= req;
    end
    if (cmd.do_evict) begin
      tag[victim] <= req;
    end
    if (cmd.scan_init) begin
      best     <= count[0];
      victim   <= '0;
      scan_idx <= WAY_W'(1);
    end else if (cmd.scan_step) begin
      if (take_scan) begin
        best   <= count[scan_idx];
        victim <= scan_idx;
      end
      scan_idx <= scan_idx + WAY_W'(1);
    end
    if (cmd.do_absent | cmd.do_hit | cmd.do_fill | cmd.do_evict) begin
      way_index     <= way_ext[OUT_WAY_W-1:0];
      use_count     <= count_ext[OUT_COUNT_W-1:0];
      evicted_value <= cmd.do_evict ? tag[victim] : '0;
      if (cmd.do_absent) begin
        outcome <= OUT_ABSENT;
      end else if (cmd.do_hit) begin
        outcome <= OUT_HIT;
      end else if (cmd.do_fill) begin
        outcome <= OUT_FILL;
      end else begin
        outcome <= OUT_EVICT;
      end
    end
  end

endmodule

// File: bench/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the count-based replacement cache. A local
// predictor tracks tags, valid bits, use counters and backing-memory words,
// and every done strobe is checked field by field against the oldest
// predicted word. Directed tests cover fill order, hits, absent values,
// eviction ties and a heavily hit way; random phases reprogram the
// backing memory and drive biased access streams, with random idling in all phases but the third.
// ----------------------------------------------------------------------------
module tb;
  import fcr_pkg::*;

  localparam int WAYS = 8;
  localparam int WORDS = 8;
  localparam int CNT_W = 16;
  localparam logic [CNT_W-1:0] COUNT_TOP = '1;
  localparam int RANDOM_ITEMS = 1450;
  localparam int HOT_ITEMS = 40;
  localparam int CYCLE_LIMIT = 3000000;

  typedef logic [WORD_W-1:0] word_set_t [REG_COUNT];

  typedef struct packed {
    outcome_t               outcome;
    logic [OUT_WAY_W-1:0]   way;
    logic [WORD_W-1:0]      evicted;
    logic [OUT_COUNT_W-1:0] count;
  } access_result_t;

  logic                     clk = 1'b0;
  logic                     rst = 1'b1;
  logic                     start = 1'b0;
  logic                     busy;
  logic signed [WORD_W-1:0] access_value = '0;
  logic                     done;
  logic [1:0]               outcome;
  logic [OUT_WAY_W-1:0]     way_index;
  logic signed [WORD_W-1:0] evicted_value;
  logic [OUT_COUNT_W-1:0]   use_count;
  logic                     cfg_valid = 1'b0;
  logic                     cfg_ready;
  logic [REG_IDX_W-1:0]     cfg_index = '0;
  logic signed [WORD_W-1:0] cfg_data = '0;

  word_set_t         backing_word = '{default: '0};
  logic [WORD_W-1:0] cached_tag [WAYS];
  logic              tag_valid [WAYS] = '{default: 1'b0};
  logic [CNT_W-1:0]  hit_count [WAYS] = '{default: '0};
  int                ways_filled = 0;

  access_result_t pending_results [$];
  access_result_t oldest;
  bit             idling_on = 1'b1;
  int             error_count = 0;
  int             cycle_count = 0;

  frequency_count_cache_replacement #(
    .CACHE_WAYS  (WAYS),
    .MEMORY_WORDS(WORDS),
    .COUNT_WIDTH (CNT_W)
  ) dut (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .access_value (access_value),
    .done         (done),
    .outcome      (outcome),
    .way_index    (way_index),
    .evicted_value(evicted_value),
    .use_count    (use_count),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  always #10 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  function automatic access_result_t predict_access(input logic [WORD_W-1:0] value);
    access_result_t r;
    logic           present;
    int             hit_way;
    int             victim;
    logic [CNT_W-1:0] best;
    r.outcome = OUT_ABSENT;
    r.way = '0;
    r.evicted = '0;
    r.count = '0;
    present = 1'b0;
    for (int k = 0; k < WORDS; k++) begin
      if (backing_word[k] == value) present = 1'b1;
    end
    if (!present) return r;
    hit_way = -1;
    for (int w = WAYS - 1; w >= 0; w--) begin
      if (tag_valid[w] && cached_tag[w] == value) hit_way = w;
    end
    if (hit_way >= 0) begin
      if (hit_count[hit_way] != COUNT_TOP) hit_count[hit_way]++;
      r.outcome = OUT_HIT;
      r.way = OUT_WAY_W'(hit_way);
      r.count = OUT_COUNT_W'(hit_count[hit_way]);
      return r;
    end
    if (ways_filled < WAYS) begin
      cached_tag[ways_filled] = value;
      tag_valid[ways_filled] = 1'b1;
      hit_count[ways_filled] = CNT_W'(1);
      r.outcome = OUT_FILL;
      r.way = OUT_WAY_W'(ways_filled);
      r.count = OUT_COUNT_W'(1);
      ways_filled++;
      return r;
    end
    victim = 0;
    best = hit_count[0];
    for (int w = 1; w < WAYS; w++) begin
      if (hit_count[w] >= best) begin
        best = hit_count[w];
        victim = w;
      end
    end
    r.outcome = OUT_EVICT;
    r.way = OUT_WAY_W'(victim);
    r.evicted = tag_valid[victim] ? cached_tag[victim] : '0;
    r.count = OUT_COUNT_W'(1);
    cached_tag[victim] = value;
    tag_valid[victim] = 1'b1;
    hit_count[victim] = CNT_W'(1);
    return r;
  endfunction

  always @(posedge clk) begin
    if (!rst && done) begin
      if (pending_results.size() == 0) begin
        $error("unexpected result word: outcome %0d way %0d", outcome, way_index);
        error_count++;
      end else begin
        oldest = pending_results.pop_front();
        if (outcome !== oldest.outcome) begin
          $error("outcome: expected %0d, actual %0d", oldest.outcome, outcome);
          error_count++;
        end
        if (way_index !== oldest.way) begin
          $error("way_index: expected %0d, actual %0d", oldest.way, way_index);
          error_count++;
        end
        if (evicted_value !== oldest.evicted) begin
          $error("evicted_value: expected %h, actual %h", oldest.evicted, evicted_value);
          error_count++;
        end
        if (use_count !== oldest.count) begin
          $error("use_count: expected %0d, actual %0d", oldest.count, use_count);
          error_count++;
        end
      end
    end
  end

  task automatic send_access(input logic [WORD_W-1:0] value);
    while (idling_on && $urandom_range(0, 99) < 23) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start <= 1'b1;
    access_value <= value;
    do @(posedge clk); while (busy);
    pending_results.push_back(predict_access(value));
  endtask

  task automatic await_results();
    start <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  task automatic load_backing_words(input word_set_t words, input logic [REG_COUNT-1:0] which);
    await_results();
    for (int i = 0; i < REG_COUNT; i++) begin
      if (which[i]) begin
        cfg_valid <= 1'b1;
        cfg_index <= REG_IDX_W'(i);
        cfg_data <= words[i];
        do @(posedge clk); while (!cfg_ready);
        backing_word[i] = words[i];
      end
    end
    cfg_valid <= 1'b0;
  endtask

  task automatic test_fill_and_hit();
    word_set_t next_words;
    next_words = '{32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0000, 32'hFFFF_FFFF,
                   32'h0000_0001, 32'h5555_5555, 32'hAAAA_AAAA, 32'h0000_0002};
    // reset words are all zero, so zero is present
    send_access(32'h0000_0000);
    send_access(32'h0000_0000);
    send_access(32'h1234_5678);
    load_backing_words(next_words, '1);
    for (int i = 0; i < REG_COUNT; i++) send_access(next_words[i]);
    send_access(32'h0000_0002);
  endtask

  task automatic test_eviction_order();
    word_set_t next_words;
    next_words = backing_word;
    next_words[4] = 32'h0000_0010;
    load_backing_words(next_words, 8'b0001_0000);
    // cached but no longer backed: absent
    send_access(32'h0000_0001);
    send_access(32'h0000_0010);
    send_access(32'h0000_0010);
    next_words[2] = 32'h0000_0020;
    load_backing_words(next_words, 8'b0000_0100);
    send_access(32'h0000_0020);
    next_words[7] = 32'h0000_0030;
    load_backing_words(next_words, 8'b1000_0000);
    send_access(32'h0000_0030);
    next_words[1] = 32'h0000_0040;
    load_backing_words(next_words, 8'b0000_0010);
    send_access(32'h0000_0040);
  endtask

  task automatic test_hot_way_eviction();
    word_set_t next_words;
    idling_on = 1'b0;
    for (int i = 0; i < HOT_ITEMS; i++) send_access(backing_word[3]);
    next_words = backing_word;
    next_words[5] = 32'h0000_0050;
    load_backing_words(next_words, 8'b0010_0000);
    // hot way holds the top count, so it goes first
    send_access(32'h0000_0050);
    idling_on = 1'b1;
  endtask

  task automatic test_random_phases();
    word_set_t             next_words;
    logic [REG_COUNT-1:0]  which;
    int                    items_done;
    int                    phase;
    int                    phase_len;
    int                    pick;
    logic [WORD_W-1:0]     value;
    items_done = 0;
    phase = 0;
    while (items_done < RANDOM_ITEMS) begin
      next_words = backing_word;
      which = REG_COUNT'($urandom_range(1, (1 << REG_COUNT) - 1));
      for (int i = 0; i < REG_COUNT; i++) begin
        pick = $urandom_range(0, 9);
        case (pick)
          0: next_words[i] = 32'h8000_0000;
          1: next_words[i] = 32'h7FFF_FFFF;
          2: next_words[i] = 32'h0000_0000;
          3: next_words[i] = 32'hFFFF_FFFF;
          4: next_words[i] = next_words[$urandom_range(0, REG_COUNT - 1)];
          default: next_words[i] = $urandom();
        endcase
      end
      load_backing_words(next_words, which);
      idling_on = (phase != 2);
      phase_len = (phase == 2) ? 300 : $urandom_range(40, 140);
      for (int n = 0; n < phase_len; n++) begin
        pick = $urandom_range(0, 99);
        if (pick < 80) value = backing_word[$urandom_range(0, $urandom_range(0, WORDS - 1))];
        else value = $urandom();
        send_access(value);
        if ($urandom_range(0, 59) == 0) await_results();
      end
      items_done += phase_len;
      phase++;
    end
    idling_on = 1'b1;
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_fill_and_hit();
    test_eviction_order();
    test_hot_way_eviction();
    test_random_phases();
    await_results();
    repeat (WAYS + 4) @(posedge clk);
    if (error_count == 0) $display("All tests passed");
    else $display("Some tests failed");
    $finish;
  end

endmodule
